>>> src/ots_pkg.sv
// Shared types, constants and codes for the offload target selector.
package ots_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ID_W   = 16;
    localparam int UTIL_W = 16;
    localparam int BLAT_W = 20;
    localparam int LAT_W  = BLAT_W + 1;
    localparam int DEC_W  = 3;

    // Front/back queue (power of two so pointers wrap naturally)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration registers
    localparam int                CFG_IDX_W      = 1;
    localparam int                CFG_DATA_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_EDGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_CAP = 1'b1;
    localparam logic [UTIL_W-1:0] CAPACITY_RESET = 16'd14;

    // Request commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_TASK   = 1'b1;

    // Decision codes
    localparam logic [DEC_W-1:0] DEC_SERVE_HERE = 3'd0;
    localparam logic [DEC_W-1:0] DEC_OTHER_EDGE = 3'd1;
    localparam logic [DEC_W-1:0] DEC_LOCAL_NODE = 3'd2;
    localparam logic [DEC_W-1:0] DEC_CLOUD      = 3'd3;
    localparam logic [DEC_W-1:0] DEC_UPDATED    = 3'd4;
    localparam logic [DEC_W-1:0] DEC_FULL       = 3'd5;

    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   edge_id;
        logic [ID_W-1:0]   node_id;
        logic [UTIL_W-1:0] utility;
        logic [BLAT_W-1:0] base_latency;
        logic [BLAT_W-1:0] extra_latency;
    } t_req;

    typedef struct packed {
        logic [DEC_W-1:0] decision;
        logic [ID_W-1:0]  target_edge;
        logic [ID_W-1:0]  target_node;
    } t_rsp;

    // Classified work item
    typedef enum logic [1:0] {
        JOB_UPDATE,
        JOB_HERE,
        JOB_SCAN
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   edge_id;
        logic [ID_W-1:0]   node_id;
        logic [UTIL_W-1:0] utility;
        logic [LAT_W-1:0]  latency;
    } t_job;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [ID_W-1:0]   edge_id;
        logic [ID_W-1:0]   node_id;
        logic [UTIL_W-1:0] utility;
        logic [LAT_W-1:0]  latency;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

>>> src/ots_front.sv
// Front end: accepts requests, classifies them and sums the latency parts.
module ots_front import ots_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [UTIL_W-1:0] i_local_capacity,
    input  logic              i_in_valid,
    input  t_req              i_in_req,
    output logic              o_in_stall,
    output logic              o_push,
    output t_job              o_push_job,
    input  t_qstat            i_qstat
);

    logic r_vld;
    logic n_vld;
    t_job r_job;
    t_job n_job;
    logic accept;

    assign o_in_stall = r_vld && i_qstat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_vld && !i_qstat.full;
    assign o_push_job = r_job;

    // Classify: update, serve here, or table scan
    always_comb begin
        n_job.edge_id = i_in_req.edge_id;
        n_job.node_id = i_in_req.node_id;
        n_job.utility = i_in_req.utility;
        n_job.latency = {1'b0, i_in_req.base_latency} + {1'b0, i_in_req.extra_latency};
        if (i_in_req.cmd == CMD_UPDATE) begin
            n_job.kind = JOB_UPDATE;
        end else if (i_local_capacity >= i_in_req.utility) begin
            n_job.kind = JOB_HERE;
        end else begin
            n_job.kind = JOB_SCAN;
        end
    end

    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

>>> src/ots_fifo.sv
// Short job queue between the front end and the table engine.
module ots_fifo import ots_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_push_job,
    input  logic   i_pop,
    output t_job   o_pop_job,
    output t_qstat o_qstat
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_qstat.full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_pop_job     = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

endmodule

>>> src/ots_back.sv
// Table engine: owns the entry memory, scans it and produces the response.
module ots_back import ots_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [ID_W-1:0] i_own_edge_id,
    input  t_job            i_job,
    input  t_qstat          i_qstat,
    output logic            o_pop,
    output logic            o_out_valid,
    output t_rsp            o_out_rsp,
    input  logic            i_out_stall
);

    t_state r_state;
    t_state n_state;

    t_job              r_job;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    t_entry            r_rd_data;
    t_entry            r_mem [TABLE_DEPTH];

    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_found;
    logic [LAT_W-1:0]  r_best_lat;
    logic [ID_W-1:0]   r_best_edge;
    logic [ID_W-1:0]   r_best_node;

    logic              r_out_vld;
    t_rsp              r_out;

    logic              out_free;
    logic              rd_en;
    logic              finish;
    logic              tbl_full;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic              grow;
    t_rsp              rsp;
    t_entry            wr_entry;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign tbl_full    = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = (i_job.kind == JOB_HERE) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == r_count && !r_rd_vld) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop  = 1'b0;
        rd_en  = 1'b0;
        finish = 1'b0;
        case (r_state)
            ST_IDLE:   o_pop  = !i_qstat.empty;
            ST_SCAN:   rd_en  = (r_addr < r_count);
            ST_FINISH: finish = out_free;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Response and table write for the finished job
    always_comb begin
        rsp       = '0;
        mem_we    = 1'b0;
        grow      = 1'b0;
        mem_waddr = r_hit ? r_hit_idx : r_count[IDX_W-1:0];
        case (r_job.kind)
            JOB_HERE: rsp.decision = DEC_SERVE_HERE;
            JOB_UPDATE: begin
                if (r_hit || !tbl_full) begin
                    rsp.decision = DEC_UPDATED;
                    mem_we       = finish;
                    grow         = finish && !r_hit;
                end else begin
                    rsp.decision = DEC_FULL;
                end
            end
            JOB_SCAN: begin
                if (r_found) begin
                    rsp.decision    = (r_best_edge == i_own_edge_id) ? DEC_LOCAL_NODE
                                                                     : DEC_OTHER_EDGE;
                    rsp.target_edge = r_best_edge;
                    rsp.target_node = r_best_node;
                end else begin
                    rsp.decision = DEC_CLOUD;
                end
            end
            default: rsp.decision = DEC_CLOUD;
        endcase
    end

    assign wr_entry.edge_id = r_job.edge_id;
    assign wr_entry.node_id = r_job.node_id;
    assign wr_entry.utility = r_job.utility;
    assign wr_entry.latency = r_job.latency;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (o_pop) begin
                r_addr  <= '0;
                r_hit   <= 1'b0;
                r_found <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_addr <= r_addr + 1'b1;
                end
                // Evaluate one entry per cycle
                if (r_rd_vld) begin
                    if (r_job.kind == JOB_UPDATE) begin
                        if (r_rd_data.edge_id == r_job.edge_id &&
                            r_rd_data.node_id == r_job.node_id) begin
                            r_hit <= 1'b1;
                        end
                    end else if (r_rd_data.utility >= r_job.utility &&
                                 (!r_found || r_rd_data.latency < r_best_lat)) begin
                        r_found <= 1'b1;
                    end
                end
            end
            if (grow) begin
                r_count <= r_count + 1'b1;
            end
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (rd_en) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
        if (r_rd_vld && !o_pop) begin
            if (r_job.kind == JOB_UPDATE) begin
                if (r_rd_data.edge_id == r_job.edge_id &&
                    r_rd_data.node_id == r_job.node_id) begin
                    r_hit_idx <= r_rd_idx;
                end
            end else if (r_rd_data.utility >= r_job.utility &&
                         (!r_found || r_rd_data.latency < r_best_lat)) begin
                r_best_lat  <= r_rd_data.latency;
                r_best_edge <= r_rd_data.edge_id;
                r_best_node <= r_rd_data.node_id;
            end
        end
        if (finish) begin
            r_out <= rsp;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= wr_entry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= r_count)
        else $error("scan address ran past entry count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_count != $past(r_count) |->
            r_count == $past(r_count) + 1'b1)
        else $error("entry count changed by other than one");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_vld)
        else $error("finished job did not reach output register");

    a_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.decision == DEC_SERVE_HERE || r_out.decision == DEC_CLOUD ||
                      r_out.decision == DEC_UPDATED || r_out.decision == DEC_FULL)
        |-> r_out.target_edge == '0 && r_out.target_node == '0)
        else $error("nonzero target on a decision without a chosen entry");

endmodule

>>> src/offload_target_selector.sv
// Top level of the offload target selector: configuration registers and wiring.
//
//  Channel | Direction | Handshake                | Payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_req  (t_req)
//  out     | output    | o_out_valid / i_out_stall| o_out_rsp (t_rsp)
//  cfg     | input     | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
//  An update or a scanning task goes through the pop, one entry read per cycle from the
//  entry memory, judging the last entry and leaving the scan, and then the result.
//  A task served here goes from the pop straight to the result, with no scan.
//  The front end and a two-entry queue keep taking requests while the engine scans.
//  Synchronous active-low reset empties the table (count to zero) and the queue.
//  A stalled response stays in the output register; the engine holds its next job.
module offload_target_selector import ots_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_req                  i_in_req,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_rsp                  o_out_rsp,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ID_W-1:0]   r_own_edge_id;
    logic [UTIL_W-1:0] r_local_cap;
    logic              push;
    t_job              push_job;
    logic              pop;
    t_job              pop_job;
    t_qstat            qstat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_edge_id <= '0;
            r_local_cap   <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_EDGE:  r_own_edge_id <= i_cfg_data[ID_W-1:0];
                CFG_LOCAL_CAP: r_local_cap   <= i_cfg_data[UTIL_W-1:0];
                default: begin
                    r_own_edge_id <= r_own_edge_id;
                end
            endcase
        end
    end

    ots_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_local_capacity (r_local_cap),
        .i_in_valid       (i_in_valid),
        .i_in_req         (i_in_req),
        .o_in_stall       (o_in_stall),
        .o_push           (push),
        .o_push_job       (push_job),
        .i_qstat          (qstat)
    );

    ots_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_qstat    (qstat)
    );

    ots_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_own_edge_id (r_own_edge_id),
        .i_job         (pop_job),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_rsp     (o_out_rsp),
        .i_out_stall   (i_out_stall)
    );

endmodule
